// ----- rtl/core/madt_pkg.sv -----
`timescale 1ns / 1ps
// ============================================================================
// madt_pkg
// Shared types, op codes and table layout constants for the MADT parser.
// ============================================================================
package madt_pkg;

    localparam int ISA_LINES_DEF   = 16;
    localparam int OFFSET_BITS_DEF = 16;

    // request op codes
    localparam logic [1:0] OP_BEGIN  = 2'd0;
    localparam logic [1:0] OP_BYTE   = 2'd1;
    localparam logic [1:0] OP_LOOKUP = 2'd2;

    // result kinds
    localparam logic KIND_SUMMARY = 1'b0;
    localparam logic KIND_LOOKUP  = 1'b1;

    // entry types and their layout sizes
    localparam logic [7:0] TYPE_LAPIC    = 8'd0;
    localparam logic [7:0] TYPE_IOAPIC   = 8'd1;
    localparam logic [7:0] TYPE_OVERRIDE = 8'd2;
    localparam logic [3:0] NEED_LAPIC    = 4'd8;
    localparam logic [3:0] NEED_IOAPIC   = 4'd12;
    localparam logic [3:0] NEED_OVERRIDE = 4'd10;
    localparam logic [3:0] NEED_NONE     = 4'd0;

    // table header
    localparam int ENTRY_FIRST    = 44;
    localparam int ENTRY_BUF      = 12;
    localparam int HDR_LEN_WORD   = 1;   // bytes 4..7
    localparam int HDR_LAPIC_WORD = 9;   // bytes 36..39

    // override flag field value meaning active low / level
    localparam logic [1:0] FLAG_SET = 2'b11;

    // line map entry: {level, polarity_low, gsi}
    localparam int MAP_W = 34;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] data_byte;
        logic       last;
        logic [7:0] isa_line;
    } madt_item_t;

    typedef struct packed {
        logic        kind;
        logic        ok;
        logic [31:0] lapic_address;
        logic [31:0] io_apic_addr;
        logic [31:0] ioapic_gsi_base;
        logic [7:0]  boot_cpu_id;
        logic [31:0] gsi;
        logic        polarity_low;
        logic        level_mode;
    } madt_result_t;

endpackage

// ----- rtl/core/madt_ram.sv -----
`timescale 1ns / 1ps
// ============================================================================
// madt_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module madt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/core/madt_in_stage.sv -----
`timescale 1ns / 1ps
// ============================================================================
// madt_in_stage
// Input register: holds one request until the engine consumes it.
// ============================================================================
module madt_in_stage (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  madt_pkg::madt_item_t in_item,
    input  logic                out_free,
    output logic                advance,
    output madt_pkg::madt_item_t item
);
    import madt_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    madt_item_t item_reg;
    logic       accept;

    assign in_ready = !valid_reg || out_free;
    assign advance  = valid_reg && out_free;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= in_item;
        end
    end

    assign item = item_reg;

endmodule

// ----- rtl/core/madt_engine.sv -----
`timescale 1ns / 1ps
// ============================================================================
// madt_engine
// Table state, entry walk, ISA override map and result formation.
// ============================================================================
module madt_engine #(
    parameter int ISA_LINES   = madt_pkg::ISA_LINES_DEF,
    parameter int OFFSET_BITS = madt_pkg::OFFSET_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  advance,
    input  madt_pkg::madt_item_t  item,
    input  logic                  rd_en,
    input  logic [7:0]            rd_line,
    output logic                  has_result,
    output madt_pkg::madt_result_t result
);
    import madt_pkg::*;

    localparam int LINE_BITS = (ISA_LINES > 1) ? $clog2(ISA_LINES) : 1;
    localparam logic [OFFSET_BITS-1:0] OFF_MAX   = '1;
    localparam logic [OFFSET_BITS-1:0] START_RST = OFFSET_BITS'(ENTRY_FIRST);
    localparam logic [8:0] LINES_LIM = 9'(ISA_LINES);

    logic [OFFSET_BITS-1:0] offset_reg, offset_next;
    logic [OFFSET_BITS-1:0] start_reg, start_next;
    logic [31:0]            tlen_reg, tlen_next;
    logic [31:0]            lapic_reg, lapic_next;
    logic                   stopped_reg, stopped_next;
    logic [31:0]            io_base_reg, io_base_next;
    logic [31:0]            io_gsi_reg, io_gsi_next;
    logic                   have_io_reg, have_io_next;
    logic [7:0]             boot_id_reg, boot_id_next;
    logic                   have_boot_reg, have_boot_next;
    logic [ISA_LINES-1:0]   map_valid_reg, map_valid_next;
    logic [7:0]             eb_reg [ENTRY_BUF];
    logic [7:0]             eb_next [ENTRY_BUF];

    // bypass for a map write landing on the same edge as the RAM read
    logic                   fwd_valid_reg, fwd_valid_next;
    logic [LINE_BITS-1:0]   fwd_line_reg, fwd_line_next;
    logic [MAP_W-1:0]       fwd_data_reg, fwd_data_next;

    logic                   wr_en;
    logic [LINE_BITS-1:0]   wr_addr;
    logic [MAP_W-1:0]       wr_data;
    logic [MAP_W-1:0]       ram_rdata;

    logic                   is_begin, is_byte, is_lookup, walk_act;
    logic [7:0]             b;
    logic [OFFSET_BITS-1:0] rel;
    logic                   rel_lt12;
    logic [3:0]             rel_idx;
    logic [7:0]             view [ENTRY_BUF];
    logic [7:0]             len, typ;
    logic [3:0]             need;
    logic                   use_it, entry_end;
    logic [1:0]             lane;
    logic [OFFSET_BITS-3:0] hdr_word;

    logic                   lk_in_range, lk_valid, lk_fwd;
    logic [LINE_BITS-1:0]   lk_idx;
    logic [MAP_W-1:0]       lk_entry;

    madt_ram #(
        .WIDTH(MAP_W),
        .DEPTH(ISA_LINES)
    ) u_map_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_line[LINE_BITS-1:0]),
        .rd_data (ram_rdata)
    );

    assign is_begin  = advance && (item.op == OP_BEGIN);
    assign is_byte   = advance && (item.op == OP_BYTE) && (offset_reg != OFF_MAX);
    assign is_lookup = advance && (item.op == OP_LOOKUP);
    assign b         = item.data_byte;

    assign walk_act = is_byte && !stopped_reg && (offset_reg >= start_reg)
                      && (32'(offset_reg) < tlen_reg);
    assign rel      = offset_reg - start_reg;
    assign rel_lt12 = rel < OFFSET_BITS'(ENTRY_BUF);
    assign rel_idx  = rel[3:0];
    assign lane     = offset_reg[1:0];
    assign hdr_word = offset_reg[OFFSET_BITS-1:2];

    // entry bytes as seen after this byte lands
    always_comb
    begin
        for (int i = 0; i < ENTRY_BUF; i++)
        begin
            view[i] = (rel_lt12 && (rel_idx == 4'(i))) ? b : eb_reg[i];
        end
    end

    assign typ = view[0];
    assign len = view[1];

    always_comb
    begin
        case (typ)
            TYPE_LAPIC:    need = NEED_LAPIC;
            TYPE_IOAPIC:   need = NEED_IOAPIC;
            TYPE_OVERRIDE: need = NEED_OVERRIDE;
            default:       need = NEED_NONE;
        endcase
    end

    assign use_it    = (need != NEED_NONE) && (len >= {4'd0, need})
                       && (rel == OFFSET_BITS'(need - 4'd1));
    assign entry_end = (len != 8'd0) && (rel == OFFSET_BITS'(len - 8'd1));

    always_comb
    begin
        offset_next    = offset_reg;
        start_next     = start_reg;
        tlen_next      = tlen_reg;
        lapic_next     = lapic_reg;
        stopped_next   = stopped_reg;
        io_base_next   = io_base_reg;
        io_gsi_next    = io_gsi_reg;
        have_io_next   = have_io_reg;
        boot_id_next   = boot_id_reg;
        have_boot_next = have_boot_reg;
        map_valid_next = map_valid_reg;
        for (int i = 0; i < ENTRY_BUF; i++)
        begin
            eb_next[i] = eb_reg[i];
        end
        wr_en   = 1'b0;
        wr_addr = view[3][LINE_BITS-1:0];
        wr_data = {(view[8][3:2] == FLAG_SET), (view[8][1:0] == FLAG_SET),
                   view[7], view[6], view[5], view[4]};

        if (is_begin)
        begin
            offset_next    = '0;
            start_next     = START_RST;
            tlen_next      = '0;
            lapic_next     = '0;
            stopped_next   = 1'b0;
            io_base_next   = '0;
            io_gsi_next    = '0;
            have_io_next   = 1'b0;
            boot_id_next   = '0;
            have_boot_next = 1'b0;
            map_valid_next = '0;
        end
        else if (is_byte)
        begin
            offset_next = offset_reg + 1'b1;
            for (int k = 0; k < 4; k++)
            begin
                if (lane == 2'(k))
                begin
                    if (hdr_word == (OFFSET_BITS-2)'(HDR_LEN_WORD))
                    begin
                        tlen_next[8*k +: 8] = b;
                    end
                    if (hdr_word == (OFFSET_BITS-2)'(HDR_LAPIC_WORD))
                    begin
                        lapic_next[8*k +: 8] = b;
                    end
                end
            end

            if (walk_act)
            begin
                if (rel_lt12)
                begin
                    eb_next[rel_idx] = b;
                end
                if (rel != '0)
                begin
                    if ((rel == OFFSET_BITS'(1)) && (b == 8'd0))
                    begin
                        stopped_next = 1'b1;
                    end
                    else
                    begin
                        if (use_it)
                        begin
                            case (typ)
                                TYPE_LAPIC:
                                begin
                                    if (view[4][0] && !have_boot_reg)
                                    begin
                                        boot_id_next   = view[3];
                                        have_boot_next = 1'b1;
                                    end
                                end
                                TYPE_IOAPIC:
                                begin
                                    if (!have_io_reg)
                                    begin
                                        io_base_next = {view[7], view[6], view[5], view[4]};
                                        io_gsi_next  = {view[11], view[10], view[9], view[8]};
                                        have_io_next = 1'b1;
                                    end
                                end
                                default:
                                begin
                                    if ({1'b0, view[3]} < LINES_LIM)
                                    begin
                                        wr_en                   = 1'b1;
                                        map_valid_next[wr_addr] = 1'b1;
                                    end
                                end
                            endcase
                        end
                        // length one: next entry starts on this length byte
                        if (len == 8'd1)
                        begin
                            start_next = offset_reg;
                            eb_next[0] = b;
                        end
                        else if (entry_end)
                        begin
                            start_next = offset_reg + 1'b1;
                        end
                    end
                end
            end
        end
    end

    always_comb
    begin
        fwd_valid_next = fwd_valid_reg;
        fwd_line_next  = fwd_line_reg;
        fwd_data_next  = fwd_data_reg;
        if (rd_en)
        begin
            fwd_valid_next = wr_en;
            fwd_line_next  = wr_addr;
            fwd_data_next  = wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg    <= '0;
            start_reg     <= START_RST;
            tlen_reg      <= '0;
            lapic_reg     <= '0;
            stopped_reg   <= 1'b0;
            io_base_reg   <= '0;
            io_gsi_reg    <= '0;
            have_io_reg   <= 1'b0;
            boot_id_reg   <= '0;
            have_boot_reg <= 1'b0;
            map_valid_reg <= '0;
            fwd_valid_reg <= 1'b0;
        end
        else
        begin
            offset_reg    <= offset_next;
            start_reg     <= start_next;
            tlen_reg      <= tlen_next;
            lapic_reg     <= lapic_next;
            stopped_reg   <= stopped_next;
            io_base_reg   <= io_base_next;
            io_gsi_reg    <= io_gsi_next;
            have_io_reg   <= have_io_next;
            boot_id_reg   <= boot_id_next;
            have_boot_reg <= have_boot_next;
            map_valid_reg <= map_valid_next;
            fwd_valid_reg <= fwd_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < ENTRY_BUF; i++)
        begin
            eb_reg[i] <= eb_next[i];
        end
        fwd_line_reg <= fwd_line_next;
        fwd_data_reg <= fwd_data_next;
    end

    // lookup: unwritten lines read as identity with flags clear
    assign lk_idx      = item.isa_line[LINE_BITS-1:0];
    assign lk_in_range = {1'b0, item.isa_line} < LINES_LIM;
    assign lk_valid    = lk_in_range && map_valid_reg[lk_idx];
    assign lk_fwd      = fwd_valid_reg && (fwd_line_reg == lk_idx);
    assign lk_entry    = lk_fwd ? fwd_data_reg : ram_rdata;

    assign has_result = (advance && (item.op == OP_BYTE) && item.last) || is_lookup;

    always_comb
    begin
        result = '0;
        if (item.op == OP_LOOKUP)
        begin
            result.kind         = KIND_LOOKUP;
            result.gsi          = lk_valid ? lk_entry[31:0] : 32'(item.isa_line);
            result.polarity_low = lk_valid && lk_entry[32];
            result.level_mode   = lk_valid && lk_entry[33];
        end
        else
        begin
            result.kind            = KIND_SUMMARY;
            result.ok              = have_io_next && (lapic_next != '0);
            result.lapic_address   = lapic_next;
            result.io_apic_addr    = io_base_next;
            result.ioapic_gsi_base = io_gsi_next;
            result.boot_cpu_id     = boot_id_next;
        end
    end

endmodule

// ----- rtl/core/madt_out_stage.sv -----
`timescale 1ns / 1ps
// ============================================================================
// madt_out_stage
// Result register: holds one result until the receiver takes it.
// ============================================================================
module madt_out_stage (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   advance,
    input  logic                   has_result,
    input  madt_pkg::madt_result_t result,
    output logic                   out_free,
    output logic                   out_valid,
    input  logic                   out_ready,
    output madt_pkg::madt_result_t out_result
);
    import madt_pkg::*;

    logic         valid_reg;
    logic         valid_next;
    madt_result_t result_reg;

    assign out_free = !valid_reg || out_ready;

    always_comb
    begin
        if (advance)
        begin
            valid_next = has_result;
        end
        else
        begin
            valid_next = valid_reg && !out_ready;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && has_result)
        begin
            result_reg <= result;
        end
    end

    assign out_valid  = valid_reg;
    assign out_result = result_reg;

endmodule

// ----- rtl/core/madt_interrupt_table_parser.sv -----
`timescale 1ns / 1ps
// ============================================================================
// madt_interrupt_table_parser
// MADT byte-stream parser with ISA interrupt override lookup.
// ============================================================================
// Usage:
//   Input channel (in_valid/in_ready) carries one request: op 0 starts a new
//   table, op 1 delivers the next table byte (last=1 on the final byte asks
//   for a summary), op 2 looks up an ISA line in the override map.
//   Output channel (out_valid/out_ready) returns a summary (kind 0) or a
//   lookup answer (kind 1). Begin requests and non-final bytes return nothing.
// Path: an accepted request is held in the input register, then its result
//   in the result register, which drives the ports.
// Throughput: one request per cycle while out_ready keeps up. The per-byte walk
//   and the override map write are worked out combinationally; the map lives in a RAM
//   whose read is launched as the request enters the input register.
// Stall: while the result register is full and out_ready is low, the input
//   register still takes one request; in_ready drops only when both hold.
// Reset: rst_n clears all table state; the override map reads as identity
//   (GSI = line, flags clear) through per-line valid bits, no clearing pass.
// ============================================================================
module madt_interrupt_table_parser #(
    parameter int ISA_LINES   = madt_pkg::ISA_LINES_DEF,
    parameter int OFFSET_BITS = madt_pkg::OFFSET_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // request channel
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  op,
    input  logic [7:0]  data_byte,
    input  logic        last,
    input  logic [7:0]  isa_line,
    // result channel
    output logic        out_valid,
    input  logic        out_ready,
    output logic        kind,
    output logic        ok,
    output logic [31:0] lapic_address,
    output logic [31:0] io_apic_addr,
    output logic [31:0] ioapic_gsi_base,
    output logic [7:0]  boot_cpu_id,
    output logic [31:0] gsi,
    output logic        polarity_low,
    output logic        level_mode
);
    import madt_pkg::*;

    madt_item_t   in_item;
    madt_item_t   item;
    madt_result_t result;
    madt_result_t out_result;
    logic         advance;
    logic         out_free;
    logic         has_result;

    assign in_item.op        = op;
    assign in_item.data_byte = data_byte;
    assign in_item.last      = last;
    assign in_item.isa_line  = isa_line;

    madt_in_stage u_in_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_item  (in_item),
        .out_free (out_free),
        .advance  (advance),
        .item     (item)
    );

    // map RAM read is issued with the request capture, so data is ready
    // when the request reaches the engine
    madt_engine #(
        .ISA_LINES   (ISA_LINES),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .item       (item),
        .rd_en      (in_valid && in_ready),
        .rd_line    (isa_line),
        .has_result (has_result),
        .result     (result)
    );

    madt_out_stage u_out_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .has_result (has_result),
        .result     (result),
        .out_free   (out_free),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_result (out_result)
    );

    assign kind            = out_result.kind;
    assign ok              = out_result.ok;
    assign lapic_address   = out_result.lapic_address;
    assign io_apic_addr    = out_result.io_apic_addr;
    assign ioapic_gsi_base = out_result.ioapic_gsi_base;
    assign boot_cpu_id     = out_result.boot_cpu_id;
    assign gsi             = out_result.gsi;
    assign polarity_low    = out_result.polarity_low;
    assign level_mode      = out_result.level_mode;

endmodule

// ----- rtl/core/madt_checker.sv -----
`timescale 1ns / 1ps
// ============================================================================
// madt_checker
// Port-level checks for the MADT parser, bound to the top level.
// ============================================================================
module madt_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic        kind,
    input logic        ok,
    input logic [31:0] lapic_address,
    input logic [31:0] io_apic_addr,
    input logic [31:0] ioapic_gsi_base,
    input logic [7:0]  boot_cpu_id,
    input logic [31:0] gsi,
    input logic        polarity_low,
    input logic        level_mode
);
    import madt_pkg::*;

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(gsi)
            && $stable(lapic_address))
        else $error("stalled result changed");

    // empty result register never blocks requests
    a_in_open: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("in_ready low with empty result register");

    a_lookup_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == KIND_LOOKUP) |-> !ok && (lapic_address == '0)
            && (io_apic_addr == '0) && (ioapic_gsi_base == '0) && (boot_cpu_id == '0))
        else $error("lookup result carries summary fields");

    a_summary_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == KIND_SUMMARY) |-> (gsi == '0) && !polarity_low && !level_mode
            && (!ok || (lapic_address != '0)))
        else $error("summary result inconsistent");

endmodule

bind madt_interrupt_table_parser madt_checker u_madt_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .kind            (kind),
    .ok              (ok),
    .lapic_address   (lapic_address),
    .io_apic_addr    (io_apic_addr),
    .ioapic_gsi_base (ioapic_gsi_base),
    .boot_cpu_id     (boot_cpu_id),
    .gsi             (gsi),
    .polarity_low    (polarity_low),
    .level_mode      (level_mode)
);

// ----- tb/sv/madt_answer_checker.sv -----
`timescale 1ns / 1ps
// ============================================================================
// madt_answer_checker
// Watches both channels of the MADT parser, predicts every answer from the
// accepted requests and compares each answer field by field, in order.
// ============================================================================
module madt_answer_checker #(
    parameter int ISA_LINES   = madt_pkg::ISA_LINES_DEF,
    parameter int OFFSET_BITS = madt_pkg::OFFSET_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [1:0]  op,
    input  logic [7:0]  data_byte,
    input  logic        last,
    input  logic [7:0]  isa_line,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic        kind,
    input  logic        ok,
    input  logic [31:0] lapic_address,
    input  logic [31:0] io_apic_addr,
    input  logic [31:0] ioapic_gsi_base,
    input  logic [7:0]  boot_cpu_id,
    input  logic [31:0] gsi,
    input  logic        polarity_low,
    input  logic        level_mode,
    output int          fail_count,
    output int          answers_due
);
    import madt_pkg::*;

    localparam longint OFF_LIMIT = (longint'(1) << OFFSET_BITS) - 1;
    localparam int     PRINT_CAP = 50;

    // shadow parser state
    longint           byte_pos;
    longint           ent_start;
    logic [31:0]      tbl_len;
    logic [31:0]      lapic_addr;
    logic [7:0]       ent_buf [ENTRY_BUF];
    logic             walk_done;
    logic [31:0]      io_addr;
    logic [31:0]      io_gsi;
    logic             have_io;
    logic [7:0]       boot_id;
    logic             have_boot;
    logic [MAP_W-1:0] line_map [ISA_LINES];

    madt_result_t     owed_answers [$];
    int               mismatches = 0;

    assign fail_count = mismatches;

    task automatic flag(input string what, input logic [31:0] want, input logic [31:0] seen);
        if (mismatches < PRINT_CAP)
            $display("%t mismatch on %s: expected %0h, got %0h", $realtime, what, want, seen);
        mismatches++;
    endtask

    function automatic void clear_table();
        byte_pos   = 0;
        ent_start  = ENTRY_FIRST;
        tbl_len    = '0;
        lapic_addr = '0;
        walk_done  = 1'b0;
        io_addr    = '0;
        io_gsi     = '0;
        have_io    = 1'b0;
        boot_id    = '0;
        have_boot  = 1'b0;
        for (int i = 0; i < ENTRY_BUF; i++)
            ent_buf[i] = '0;
        for (int i = 0; i < ISA_LINES; i++)
            line_map[i] = MAP_W'(i);
    endfunction

    function automatic logic [31:0] ent_word(input int pos);
        return {ent_buf[pos + 3], ent_buf[pos + 2], ent_buf[pos + 1], ent_buf[pos]};
    endfunction

    // entry layout complete: capture what it describes
    function automatic void take_entry(input logic [7:0] etype);
        logic [7:0] fl;
        int         line;
        if (etype == TYPE_LAPIC)
        begin
            if (ent_buf[4][0] && !have_boot)
            begin
                boot_id   = ent_buf[3];
                have_boot = 1'b1;
            end
        end
        else if (etype == TYPE_IOAPIC)
        begin
            if (!have_io)
            begin
                io_addr = ent_word(4);
                io_gsi  = ent_word(8);
                have_io = 1'b1;
            end
        end
        else
        begin
            line = ent_buf[3];
            fl   = ent_buf[8];
            if (line < ISA_LINES)
                line_map[line] = {fl[3:2] == FLAG_SET, fl[1:0] == FLAG_SET, ent_word(4)};
        end
    endfunction

    function automatic void walk_entry_byte(input longint pos, input logic [7:0] b);
        longint     rel;
        int         len;
        int         need;
        logic [7:0] etype;
        if (walk_done || pos < ent_start || pos >= longint'({32'd0, tbl_len}))
            return;
        rel = pos - ent_start;
        if (rel < ENTRY_BUF)
            ent_buf[rel] = b;
        if (rel == 0)
            return;
        if (rel == 1 && b == 8'd0)
        begin
            walk_done = 1'b1;
            return;
        end
        len   = ent_buf[1];
        etype = ent_buf[0];
        if (etype == TYPE_LAPIC)
            need = NEED_LAPIC;
        else if (etype == TYPE_IOAPIC)
            need = NEED_IOAPIC;
        else if (etype == TYPE_OVERRIDE)
            need = NEED_OVERRIDE;
        else
            need = NEED_NONE;
        if (need != 0 && len >= need && rel == need - 1)
            take_entry(etype);
        if (len == 1)
        begin
            // length one: the next entry starts on this very byte
            ent_start  = pos;
            ent_buf[0] = b;
        end
        else if (rel == len - 1)
            ent_start = pos + 1;
    endfunction

    function automatic void take_table_byte(input logic [7:0] b);
        longint pos;
        pos = byte_pos;
        if (pos >= OFF_LIMIT)
            return;
        if (pos >= 4 && pos < 8)
            tbl_len = tbl_len | (32'(b) << (8 * (pos - 4)));
        else if (pos >= 36 && pos < 40)
            lapic_addr = lapic_addr | (32'(b) << (8 * (pos - 36)));
        walk_entry_byte(pos, b);
        byte_pos = pos + 1;
    endfunction

    function automatic void apply_request(input logic [1:0] r_op, input logic [7:0] r_data,
                                          input logic r_last, input logic [7:0] r_line);
        madt_result_t ans;
        ans = '0;
        case (r_op)
            OP_BEGIN:
                clear_table();
            OP_BYTE:
            begin
                take_table_byte(r_data);
                if (r_last)
                begin
                    ans.kind            = KIND_SUMMARY;
                    ans.ok              = have_io && lapic_addr != '0;
                    ans.lapic_address   = lapic_addr;
                    ans.io_apic_addr    = io_addr;
                    ans.ioapic_gsi_base = io_gsi;
                    ans.boot_cpu_id     = boot_id;
                    owed_answers.push_back(ans);
                end
            end
            OP_LOOKUP:
            begin
                ans.kind = KIND_LOOKUP;
                if (int'(r_line) < ISA_LINES)
                    {ans.level_mode, ans.polarity_low, ans.gsi} = line_map[r_line];
                else
                    ans.gsi = {24'd0, r_line};
                owed_answers.push_back(ans);
            end
            default:
                ;
        endcase
    endfunction

    task automatic check_answer(input madt_result_t want);
        if (kind !== want.kind)
            flag("kind", 32'(want.kind), 32'(kind));
        if (ok !== want.ok)
            flag("ok", 32'(want.ok), 32'(ok));
        if (lapic_address !== want.lapic_address)
            flag("lapic_address", want.lapic_address, lapic_address);
        if (io_apic_addr !== want.io_apic_addr)
            flag("io_apic_addr", want.io_apic_addr, io_apic_addr);
        if (ioapic_gsi_base !== want.ioapic_gsi_base)
            flag("ioapic_gsi_base", want.ioapic_gsi_base, ioapic_gsi_base);
        if (boot_cpu_id !== want.boot_cpu_id)
            flag("boot_cpu_id", 32'(want.boot_cpu_id), 32'(boot_cpu_id));
        if (gsi !== want.gsi)
            flag("gsi", want.gsi, gsi);
        if (polarity_low !== want.polarity_low)
            flag("polarity_low", 32'(want.polarity_low), 32'(polarity_low));
        if (level_mode !== want.level_mode)
            flag("level_mode", 32'(want.level_mode), 32'(level_mode));
    endtask

    // answers leave before this edge's request is taken in
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_table();
            owed_answers.delete();
            answers_due <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (owed_answers.size() == 0)
                    flag("answer with none owed", 32'd0, 32'(kind));
                else
                    check_answer(owed_answers.pop_front());
            end
            if (in_valid && in_ready)
                apply_request(op, data_byte, last, isa_line);
            answers_due <= owed_answers.size();
        end
    end

endmodule

// ----- tb/sv/madt_interrupt_table_parser_tb.sv -----
`timescale 1ns / 1ps
// ============================================================================
// madt_interrupt_table_parser_tb
// Drives the MADT parser with reset-state lookups, generated tables with
// every entry kind (short, long, unknown, length one, terminator), lookups
// and stray requests.
// A checker beside the block predicts and compares every answer.
// ============================================================================
module madt_interrupt_table_parser_tb;
    import madt_pkg::*;

    // op code with no meaning: the block must drop it
    localparam logic [1:0] OP_NONE = 2'd3;

    localparam int RANDOM_ITEMS = 1800;
    localparam int LONG_HOLD    = 300;     // receiver hold-off, in cycles
    localparam int DRAIN_LIMIT  = 5000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  op;
    logic [7:0]  data_byte;
    logic        last;
    logic [7:0]  isa_line;
    logic        out_valid;
    logic        out_ready;
    logic        kind;
    logic        ok;
    logic [31:0] lapic_address;
    logic [31:0] io_apic_addr;
    logic [31:0] ioapic_gsi_base;
    logic [7:0]  boot_cpu_id;
    logic [31:0] gsi;
    logic        polarity_low;
    logic        level_mode;

    int          fail_count;
    int          answers_due;

    // sender pacing: gaps only between bursts, and only while pace is set
    bit          pace;
    int          burst_left;
    int          sent;
    // bumped by the stimulus to ask the receiver for one long hold-off
    int          hold_reqs;

    logic [7:0]  table_bytes [$];

    madt_interrupt_table_parser dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .op              (op),
        .data_byte       (data_byte),
        .last            (last),
        .isa_line        (isa_line),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .kind            (kind),
        .ok              (ok),
        .lapic_address   (lapic_address),
        .io_apic_addr    (io_apic_addr),
        .ioapic_gsi_base (ioapic_gsi_base),
        .boot_cpu_id     (boot_cpu_id),
        .gsi             (gsi),
        .polarity_low    (polarity_low),
        .level_mode      (level_mode)
    );

    madt_answer_checker u_answer_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .op              (op),
        .data_byte       (data_byte),
        .last            (last),
        .isa_line        (isa_line),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .kind            (kind),
        .ok              (ok),
        .lapic_address   (lapic_address),
        .io_apic_addr    (io_apic_addr),
        .ioapic_gsi_base (ioapic_gsi_base),
        .boot_cpu_id     (boot_cpu_id),
        .gsi             (gsi),
        .polarity_low    (polarity_low),
        .level_mode      (level_mode),
        .fail_count      (fail_count),
        .answers_due     (answers_due)
    );

    initial
    begin
        clk = 1'b0;
        forever
            #5 clk = ~clk;
    end

    // watchdog, far beyond the slowest passing run
    initial
    begin
        #(5_000_000);
        $display("Regression FAIL");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Receiver: stretches of always-ready, coin-flip, periodic from the tick counter and
    // mostly-stalled, plus one long hold-off on request from the stimulus.
    // Exactly one assignment to out_ready per edge.
    // ------------------------------------------------------------------------
    initial
    begin
        int mode;
        int run_left;
        int hold_left;
        int hold_seen;
        int tick;
        mode      = 0;
        run_left  = 0;
        hold_left = 0;
        hold_seen = 0;
        tick      = 0;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            tick++;
            if (hold_seen != hold_reqs)
            begin
                hold_seen = hold_reqs;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                if (run_left == 0)
                begin
                    mode     = $urandom_range(0, 3);
                    run_left = $urandom_range(1, 40);
                end
                run_left--;
                case (mode)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= 1'($urandom);
                    2:       out_ready <= (tick % 3 == 0);
                    default: out_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sender helpers
    // ------------------------------------------------------------------------

    // Offer one request and hold it until accepted. A new burst may open
    // with a gap; valid stays high between requests of one burst.
    task automatic send_req(input logic [1:0] r_op, input logic [7:0] r_data,
                            input logic r_last, input logic [7:0] r_line);
        int gap;
        if (pace && burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        if (burst_left > 0)
            burst_left--;
        in_valid  <= 1'b1;
        op        <= r_op;
        data_byte <= r_data;
        last      <= r_last;
        isa_line  <= r_line;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sent++;
    endtask

    // Sender goes quiet until every owed answer has come back.
    task automatic wait_drained();
        int n;
        in_valid  <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        for (n = 0; n < DRAIN_LIMIT && answers_due != 0; n++)
            @(posedge clk);
    endtask

    // Build one MADT image into table_bytes: random header, a random mix of
    // entries, then a length field that usually matches the image.
    task automatic build_table();
        logic [7:0]  body [16];
        logic [31:0] tlen;
        int          n_ent;
        int          pick;
        int          need;
        int          len;
        int          total;
        int          i;
        table_bytes.delete();
        repeat (44)
            table_bytes.push_back(8'($urandom));
        // sometimes no local APIC address: summary must not report ok
        if ($urandom_range(0, 5) == 0)
            for (i = 36; i < 40; i++)
                table_bytes[i] = 8'h00;
        n_ent = $urandom_range(0, 10);
        repeat (n_ent)
        begin
            for (i = 0; i < 16; i++)
                body[i] = 8'($urandom);
            pick = $urandom_range(0, 11);
            need = NEED_NONE;
            if (pick <= 2)
            begin
                body[0] = TYPE_LAPIC;
                need    = NEED_LAPIC;
            end
            else if (pick <= 4)
            begin
                body[0] = TYPE_IOAPIC;
                need    = NEED_IOAPIC;
            end
            else if (pick <= 8)
            begin
                body[0] = TYPE_OVERRIDE;
                need    = NEED_OVERRIDE;
                // mostly lines in the map, sometimes past it
                if ($urandom_range(0, 4) != 0)
                    body[3] = 8'($urandom_range(0, ISA_LINES_DEF - 1));
            end
            else if (pick == 9)
                body[0] = 8'($urandom_range(3, 255));
            if (pick >= 10)
            begin
                // length one (next entry starts on the length byte) or the
                // zero-length entry that ends the walk
                table_bytes.push_back(body[0]);
                table_bytes.push_back((pick == 10) ? 8'd1 : 8'd0);
            end
            else
            begin
                if (need == NEED_NONE)
                    len = $urandom_range(2, 16);
                else
                    case ($urandom_range(0, 9))
                        0:       len = need - $urandom_range(1, 3);   // too short: skipped
                        1:       len = need + $urandom_range(1, 4);   // padded
                        default: len = need;
                    endcase
                body[1] = 8'(len);
                for (i = 0; i < len; i++)
                    table_bytes.push_back(body[i]);
            end
        end
        total = table_bytes.size();
        case ($urandom_range(0, 9))
            0:       tlen = $urandom_range(0, 45);                  // no entry walked
            1:       tlen = total - $urandom_range(1, 6);           // cuts the last entry
            2:       tlen = total + $urandom_range(1, 20);
            3:       tlen = 32'hFFFF_FFFF - $urandom_range(0, 255);
            default: tlen = total;
        endcase
        for (i = 0; i < 4; i++)
            table_bytes[4 + i] = tlen[8 * i +: 8];
        // trailing bytes past the declared end
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 5))
                table_bytes.push_back(8'($urandom));
    endtask

    // Begin, then the bytes of table_bytes; last on the final byte unless the table
    // is cut short, and now and then on other bytes. Stray lookups and dead ops are mixed in.
    task automatic send_table(input bit cut_short);
        int n;
        int i;
        n = cut_short ? $urandom_range(1, table_bytes.size()) : table_bytes.size();
        send_req(OP_BEGIN, 8'($urandom), 1'($urandom), 8'($urandom));
        for (i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 49) == 0)
                send_req($urandom_range(0, 1) ? OP_LOOKUP : OP_NONE, 8'($urandom),
                         1'($urandom), 8'($urandom));
            send_req(OP_BYTE, table_bytes[i],
                     (!cut_short && i == n - 1) || $urandom_range(0, 59) == 0,
                     8'($urandom));
        end
    endtask

    task automatic lookup_sweep(input int count);
        repeat (count)
            send_req(OP_LOOKUP, 8'($urandom), 1'($urandom),
                     ($urandom_range(0, 9) < 8) ? 8'($urandom_range(0, ISA_LINES_DEF - 1))
                                                : 8'($urandom));
    endtask

    // ------------------------------------------------------------------------
    // Stimulus and verdict
    // ------------------------------------------------------------------------
    initial
    begin
        int  pick;
        int  i;
        int  n;
        bit  pressed;
        rst_n      <= 1'b0;
        in_valid   <= 1'b0;
        op         <= OP_BEGIN;
        data_byte  <= 8'h00;
        last       <= 1'b0;
        isa_line   <= 8'h00;
        pace       = 1'b1;
        burst_left = 0;
        sent       = 0;
        hold_reqs  = 0;
        pressed    = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: map edges straight out of reset, dead op with last set,
        // begin with last set, summaries of an empty table
        send_req(OP_LOOKUP, 8'h00, 1'b0, 8'd0);
        send_req(OP_LOOKUP, 8'hFF, 1'b1, 8'(ISA_LINES_DEF - 1));
        send_req(OP_LOOKUP, 8'h00, 1'b0, 8'(ISA_LINES_DEF));
        send_req(OP_LOOKUP, 8'hA5, 1'b1, 8'hFF);
        send_req(OP_NONE, 8'hFF, 1'b1, 8'hFF);
        send_req(OP_BEGIN, 8'hFF, 1'b1, 8'hFF);
        send_req(OP_BYTE, 8'h00, 1'b1, 8'h00);
        send_req(OP_BYTE, 8'hFF, 1'b1, 8'hFF);
        send_req(OP_BYTE, 8'h5A, 1'b0, 8'h0F);
        send_req(OP_BEGIN, 8'h00, 1'b0, 8'h00);
        send_req(OP_BYTE, 8'h01, 1'b1, 8'h00);
        send_req(OP_LOOKUP, 8'h00, 1'b0, 8'd7);
        wait_drained();

        // random: mostly whole tables followed by lookups
        while (sent < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 19);
            if (pick == 0)
            begin
                // noise: any op, any field
                n = $urandom_range(5, 30);
                for (i = 0; i < n; i++)
                    send_req(2'($urandom), 8'($urandom),
                             $urandom_range(0, 7) == 0, 8'($urandom));
            end
            else if (pick == 1)
            begin
                // table abandoned part way
                build_table();
                send_table(1'b1);
            end
            else
            begin
                build_table();
                send_table(1'b0);
                lookup_sweep($urandom_range(4, 20));
            end

            if ($urandom_range(0, 5) == 0)
                wait_drained();

            // back-pressure: receiver holds off while lookups keep coming,
            // so the block fills and drops in_ready
            if (!pressed && sent > RANDOM_ITEMS / 3)
            begin
                pressed = 1'b1;
                wait_drained();
                hold_reqs++;
                pace = 1'b0;
                lookup_sweep(40);
                pace = 1'b1;
                wait_drained();
            end
        end

        // closing lookups over the map left by the last table
        lookup_sweep(ISA_LINES_DEF);

        wait_drained();
        repeat (20) @(posedge clk);
        if (fail_count == 0 && answers_due == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
